// ===== design/dpe_pkg.sv =====
`default_nettype none
package dpe_pkg;

  localparam int POINT_COUNT  = 7;
  localparam int OPP_COUNT    = 7;
  localparam int DOMAIN_COUNT = 4;

  localparam int DOM_W   = 2;
  localparam int FREQ_W  = 16;
  localparam int VOLT_W  = 16;
  localparam int POWER_W = 32;

  localparam int PT_W  = $clog2(POINT_COUNT);
  localparam int OPP_W = $clog2(OPP_COUNT + 1);

  // Quotient bits per divider, one bit per pipeline stage
  localparam int IDIV_STEPS = 32;
  localparam int SDIV_STEPS = 64;

  localparam logic [15:0] MEAS_FREQ [DOMAIN_COUNT][POINT_COUNT] = '{
    '{16'd2500, 16'd2400, 16'd2200, 16'd1500, 16'd1200, 16'd800, 16'd100},
    '{16'd2600, 16'd2500, 16'd2200, 16'd1500, 16'd1200, 16'd800, 16'd100},
    '{16'd2300, 16'd2200, 16'd2100, 16'd1500, 16'd1200, 16'd800, 16'd100},
    '{16'd2200, 16'd2100, 16'd1800, 16'd1500, 16'd1200, 16'd800, 16'd100}
  };

  localparam logic [15:0] MEAS_POWER [DOMAIN_COUNT][POINT_COUNT] = '{
    '{16'd5000, 16'd4500, 16'd3500, 16'd2000, 16'd1600, 16'd500, 16'd50},
    '{16'd5100, 16'd4700, 16'd3600, 16'd2000, 16'd1600, 16'd500, 16'd50},
    '{16'd3500, 16'd3200, 16'd3000, 16'd1900, 16'd1500, 16'd500, 16'd50},
    '{16'd3500, 16'd3300, 16'd2800, 16'd1900, 16'd1500, 16'd500, 16'd50}
  };

  localparam logic [OPP_W-1:0] OPP_SIZE [DOMAIN_COUNT] = '{
    OPP_W'(7), OPP_W'(7), OPP_W'(7), OPP_W'(6)
  };

  // Entries past a domain's size are never used
  localparam logic [15:0] OPP_FREQ [DOMAIN_COUNT][OPP_COUNT] = '{
    '{16'd800, 16'd1200, 16'd1500, 16'd1800, 16'd2200, 16'd2400, 16'd2500},
    '{16'd800, 16'd1200, 16'd1500, 16'd1800, 16'd2200, 16'd2500, 16'd2600},
    '{16'd800, 16'd1200, 16'd1500, 16'd1800, 16'd2100, 16'd2200, 16'd2300},
    '{16'd800, 16'd1200, 16'd1500, 16'd1800, 16'd2100, 16'd2200, 16'd0}
  };

  localparam logic [15:0] OPP_VOLT [DOMAIN_COUNT][OPP_COUNT] = '{
    '{16'd750, 16'd750, 16'd790, 16'd790, 16'd790, 16'd850, 16'd920},
    '{16'd750, 16'd750, 16'd790, 16'd790, 16'd790, 16'd850, 16'd920},
    '{16'd750, 16'd750, 16'd790, 16'd790, 16'd790, 16'd850, 16'd890},
    '{16'd750, 16'd750, 16'd790, 16'd790, 16'd850, 16'd890, 16'd0}
  };

  // One interpolation segment: lo + span_y * dx / span_x
  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] span_y;
    logic [31:0] dx;
    logic [15:0] span_x;
  } seg_t;

  // Interpolation divider stage; num shifts dividend out and quotient in
  typedef struct packed {
    logic [31:0] num;
    logic [15:0] den;
    logic [15:0] rem;
    logic [31:0] lo;
  } idiv_t;

  // Handoff from interpolation to voltage scaling
  typedef struct packed {
    logic        valid;
    logic [31:0] base;
    logic [15:0] vref;
    logic [15:0] volt;
  } scale_in_t;

  // Scaling divider stage
  typedef struct packed {
    logic        bypass;
    logic [31:0] base;
    logic [63:0] nq;
    logic [31:0] den;
    logic [31:0] rem;
  } sdiv_t;

endpackage
`default_nettype wire

// ===== design/dpe_scale_div.sv =====
`default_nettype none
module dpe_scale_div import dpe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  scale_in_t sc_in,
  output logic      res_valid,
  output sdiv_t     res
);

  function automatic sdiv_t sdiv_step(sdiv_t s);
    sdiv_t       r;
    logic [32:0] trial;
    r     = s;
    trial = {s.rem, s.nq[63]};
    r.nq  = {s.nq[62:0], 1'b0};
    if (trial >= {1'b0, s.den}) begin
      r.rem   = 32'(trial - {1'b0, s.den});
      r.nq[0] = 1'b1;
    end else begin
      r.rem = trial[31:0];
    end
    return r;
  endfunction

  logic        m1_valid;
  logic [47:0] m1_bv;
  logic [31:0] m1_vv;
  logic [15:0] m1_volt;
  logic [31:0] m1_base;
  logic        m1_bypass;

  logic  sd_valid [SDIV_STEPS+1];
  sdiv_t sd       [SDIV_STEPS+1];

  // Form base*V and Vref^2
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (adv) begin
      m1_valid <= sc_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_bv     <= 48'(sc_in.base) * 48'(sc_in.volt);
      m1_vv     <= 32'(sc_in.vref) * 32'(sc_in.vref);
      m1_volt   <= sc_in.volt;
      m1_base   <= sc_in.base;
      m1_bypass <= (sc_in.volt <= sc_in.vref) || (sc_in.vref == 16'd0);
    end
  end

  // Finish the numerator, load the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      sd_valid[0] <= 1'b0;
    end else if (adv) begin
      sd_valid[0] <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0].bypass <= m1_bypass;
      sd[0].base   <= m1_base;
      sd[0].nq     <= 64'(m1_bv) * 64'(m1_volt);
      sd[0].den    <= m1_bypass ? 32'd1 : m1_vv;
      sd[0].rem    <= '0;
    end
  end

  for (genvar k = 0; k < SDIV_STEPS; k++) begin : g_sdiv
    always_ff @(posedge clk) begin
      if (rst) begin
        sd_valid[k+1] <= 1'b0;
      end else if (adv) begin
        sd_valid[k+1] <= sd_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd[k+1] <= sdiv_step(sd[k]);
      end
    end
  end

  assign res_valid = sd_valid[SDIV_STEPS];
  assign res       = sd[SDIV_STEPS];

endmodule
`default_nettype wire

// ===== design/dvfs_power_estimate_unit.sv =====
`default_nettype none
// DVFS power estimate. Each transfer names a CPU domain, a frequency in MHz and
// a requested voltage in mV, and returns one power estimate. Base power is
// interpolated from the domain's measured power table (exact points returned
// as is, extrapolated past either end with 32-bit wrapping); a reference
// voltage is interpolated from the operating-point table and clamped at its
// ends. When the requested voltage is above a nonzero reference, the result is
// ceil(base * V^2 / Vref^2) truncated to 32 bits, else the base power.
// One item enters every cycle while the pipe is not held. Two restoring divider
// pipes retire one quotient bit per stage (32 for both interpolations, 64
// for voltage scaling). The whole pipe advances together: it holds while a
// result waits on result_stall, and item_stall mirrors that hold.
module dvfs_power_estimate_unit import dpe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [DOM_W-1:0]   domain_select,
  input  logic [FREQ_W-1:0]  frequency_mhz,
  input  logic [VOLT_W-1:0]  voltage_mv,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [POWER_W-1:0] power_estimate
);

  function automatic idiv_t idiv_step(idiv_t s);
    idiv_t       r;
    logic [16:0] trial;
    r     = s;
    trial = {s.rem, s.num[31]};
    r.num = {s.num[30:0], 1'b0};
    if (trial >= {1'b0, s.den}) begin
      r.rem    = 16'(trial - {1'b0, s.den});
      r.num[0] = 1'b1;
    end else begin
      r.rem = trial[15:0];
    end
    return r;
  endfunction

  logic adv;

  // Advance whenever the output register is empty or being taken
  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;

  // ---------------------------------------------------------------
  // Segment selection
  // ---------------------------------------------------------------
  logic [DOM_W-1:0] dom;
  seg_t             bp_seg, rv_seg;

  assign dom = (32'(domain_select) >= DOMAIN_COUNT) ? DOM_W'(DOMAIN_COUNT - 1)
                                                    : domain_select;

  // Measured table is descending: take the first point at or below f
  always_comb begin
    logic            found, exact;
    logic [PT_W-1:0] hit, seg;
    logic [15:0]     lo_f, hi_f, lo_p, hi_p;
    found = 1'b0;
    exact = 1'b0;
    hit   = '0;
    for (int i = 0; i < POINT_COUNT; i++) begin
      if (!found && MEAS_FREQ[dom][i] <= frequency_mhz) begin
        found = 1'b1;
        hit   = PT_W'(i);
        exact = (MEAS_FREQ[dom][i] == frequency_mhz);
      end
    end
    if (!found) begin
      seg = PT_W'(POINT_COUNT - 1);
    end else if (hit == '0) begin
      seg = PT_W'(1);
    end else begin
      seg = hit;
    end
    lo_f = MEAS_FREQ[dom][seg];
    hi_f = MEAS_FREQ[dom][seg - PT_W'(1)];
    lo_p = MEAS_POWER[dom][seg];
    hi_p = MEAS_POWER[dom][seg - PT_W'(1)];
    if (exact) begin
      bp_seg.lo     = 32'(MEAS_POWER[dom][hit]);
      bp_seg.span_y = '0;
      bp_seg.dx     = '0;
      bp_seg.span_x = '0;
    end else begin
      bp_seg.lo     = 32'(lo_p);
      bp_seg.span_y = 32'(hi_p) - 32'(lo_p);
      bp_seg.dx     = 32'(frequency_mhz) - 32'(lo_f);
      bp_seg.span_x = hi_f - lo_f;
    end
  end

  // Operating points are ascending: clamp below the first and past the last
  always_comb begin
    logic             found;
    logic [OPP_W-1:0] n, hit;
    logic [15:0]      lo_f;
    n = OPP_SIZE[dom];
    if (32'(n) > OPP_COUNT) begin
      n = OPP_W'(OPP_COUNT);
    end
    if (n == '0) begin
      n = OPP_W'(1);
    end
    found = 1'b0;
    hit   = OPP_W'(1);
    for (int i = 1; i < OPP_COUNT; i++) begin
      if (!found && 32'(i) < 32'(n) && frequency_mhz <= OPP_FREQ[dom][i]) begin
        found = 1'b1;
        hit   = OPP_W'(i);
      end
    end
    lo_f          = OPP_FREQ[dom][hit - OPP_W'(1)];
    rv_seg.span_y = '0;
    rv_seg.dx     = '0;
    rv_seg.span_x = '0;
    if (frequency_mhz <= OPP_FREQ[dom][0]) begin
      rv_seg.lo = 32'(OPP_VOLT[dom][0]);
    end else if (found) begin
      rv_seg.lo     = 32'(OPP_VOLT[dom][hit - OPP_W'(1)]);
      rv_seg.span_y = 32'(OPP_VOLT[dom][hit]) - 32'(OPP_VOLT[dom][hit - OPP_W'(1)]);
      rv_seg.dx     = 32'(frequency_mhz) - 32'(lo_f);
      rv_seg.span_x = OPP_FREQ[dom][hit] - lo_f;
    end else begin
      rv_seg.lo = 32'(OPP_VOLT[dom][n - OPP_W'(1)]);
    end
  end

  logic        s1_valid;
  seg_t        s1_bp, s1_rv;
  logic [15:0] s1_volt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_bp   <= bp_seg;
      s1_rv   <= rv_seg;
      s1_volt <= voltage_mv;
    end
  end

  // ---------------------------------------------------------------
  // Products, then a bit-per-stage divide for both interpolations
  // ---------------------------------------------------------------
  logic        dv_valid [IDIV_STEPS+1];
  idiv_t       dv_bp    [IDIV_STEPS+1];
  idiv_t       dv_rv    [IDIV_STEPS+1];
  logic [15:0] dv_volt  [IDIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= s1_valid;
    end
  end

  // A zero span gives a zero step: divide 0 by 1
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_bp[0].num <= (s1_bp.span_x == '0) ? '0 : s1_bp.span_y * s1_bp.dx;
      dv_bp[0].den <= (s1_bp.span_x == '0) ? 16'd1 : s1_bp.span_x;
      dv_bp[0].rem <= '0;
      dv_bp[0].lo  <= s1_bp.lo;
      dv_rv[0].num <= (s1_rv.span_x == '0) ? '0 : s1_rv.span_y * s1_rv.dx;
      dv_rv[0].den <= (s1_rv.span_x == '0) ? 16'd1 : s1_rv.span_x;
      dv_rv[0].rem <= '0;
      dv_rv[0].lo  <= s1_rv.lo;
      dv_volt[0]   <= s1_volt;
    end
  end

  for (genvar k = 0; k < IDIV_STEPS; k++) begin : g_idiv
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_bp[k+1]   <= idiv_step(dv_bp[k]);
        dv_rv[k+1]   <= idiv_step(dv_rv[k]);
        dv_volt[k+1] <= dv_volt[k];
      end
    end
  end

  // Add the segment base; the reference voltage wraps to 16 bits
  scale_in_t sc_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_in <= '0;
    end else if (adv) begin
      sc_in.valid <= dv_valid[IDIV_STEPS];
      sc_in.base  <= dv_bp[IDIV_STEPS].lo + dv_bp[IDIV_STEPS].num;
      sc_in.vref  <= 16'(dv_rv[IDIV_STEPS].lo + dv_rv[IDIV_STEPS].num);
      sc_in.volt  <= dv_volt[IDIV_STEPS];
    end
  end

  // ---------------------------------------------------------------
  // Voltage scaling and output register
  // ---------------------------------------------------------------
  logic  sd_valid;
  sdiv_t sd_res;

  dpe_scale_div u_scale (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .sc_in     (sc_in),
    .res_valid (sd_valid),
    .res       (sd_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= sd_valid;
    end
  end

  // Round up on a nonzero remainder; drop quotient bits above 32; bypass passes the base
  always_ff @(posedge clk) begin
    if (adv) begin
      power_estimate <= sd_res.bypass ? sd_res.base
                      : sd_res.nq[31:0] + 32'(sd_res.rem != '0);
    end
  end

endmodule
`default_nettype wire
